/* hdl/abpf_pkg.sv */
// shared types and constants for the affine background pixel fetch block
`default_nettype none

package abpf_pkg;

   // default geometry and store sizes
   localparam int SCREEN_WIDTH_DEF  = 240;
   localparam int SCREEN_HEIGHT_DEF = 160;
   localparam int VIDEO_BYTES_DEF   = 98304;
   localparam int PALETTE_ENTRIES   = 256;

   // field widths
   localparam int STORE_ADDR_W = 17;
   localparam int PIXEL_W      = 8;
   localparam int VALUE_W      = 15;
   localparam int COLOUR_W     = 15;
   localparam int PAL_ADDR_W   = 8;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 28;

   // fixed-point widths
   localparam int STEP_W   = 16;
   localparam int ORIGIN_W = 28;
   localparam int PROD_W   = 25;  // 9-bit signed coordinate times 16-bit step
   localparam int SUM_W    = 29;
   localparam int TEXEL_W  = SUM_W - 8;

   typedef enum logic [1:0] {
      CMD_RENDER        = 2'd0,
      CMD_VIDEO_WRITE   = 2'd1,
      CMD_PALETTE_WRITE = 2'd2
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_BG_CONTROL     = 3'd0,
      REG_STEP_X_PER_COL = 3'd1,
      REG_STEP_X_PER_ROW = 3'd2,
      REG_STEP_Y_PER_COL = 3'd3,
      REG_STEP_Y_PER_ROW = 3'd4,
      REG_ORIGIN_X       = 3'd5,
      REG_ORIGIN_Y       = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic        [15:0]         bg_control;
      logic signed [STEP_W-1:0]   step_x_per_col;
      logic signed [STEP_W-1:0]   step_x_per_row;
      logic signed [STEP_W-1:0]   step_y_per_col;
      logic signed [STEP_W-1:0]   step_y_per_row;
      logic signed [ORIGIN_W-1:0] origin_x;
      logic signed [ORIGIN_W-1:0] origin_y;
   } cfg_type;

   typedef struct packed {
      logic load;    // capture coordinate products
      logic sum_en;  // form the floored texel position
   } addr_ctrl_type;

   typedef struct packed {
      logic [STORE_ADDR_W-1:0] map_addr;
      logic                    map_miss;
      logic [STORE_ADDR_W-1:0] pattern_addr;
      logic                    tile_miss;
   } addr_stat_type;

endpackage

`default_nettype wire

/* hdl/abpf_ram.sv */
// generic single-clock ram, one write port and one registered read port
`default_nettype none

module abpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/abpf_addr.sv */
// texture coordinate datapath: affine transform, wrap or clip, map and tile addresses
`default_nettype none

module abpf_addr import abpf_pkg::*; #(
   parameter int VIDEO_BYTES = VIDEO_BYTES_DEF
) (
   input  wire logic                clock,
   input  wire cfg_type             cfg,
   input  wire logic [PIXEL_W-1:0]  pixel_x,
   input  wire logic [PIXEL_W-1:0]  pixel_y,
   input  wire addr_ctrl_type       ctrl,
   input  wire logic [7:0]          tile_entry,
   output addr_stat_type            stat
);

   logic signed [PROD_W-1:0]  prod_xa_ff, prod_xa_in;
   logic signed [PROD_W-1:0]  prod_xb_ff, prod_xb_in;
   logic signed [PROD_W-1:0]  prod_yc_ff, prod_yc_in;
   logic signed [PROD_W-1:0]  prod_yd_ff, prod_yd_in;
   logic signed [SUM_W-1:0]   sum_x, sum_y;
   logic signed [TEXEL_W-1:0] fx_ff, fx_in;
   logic signed [TEXEL_W-1:0] fy_ff, fy_in;

   logic [1:0]              map_size;
   logic                    wrap;
   logic [15:0]             map_base;
   logic [15:0]             pattern_base;
   logic [10:0]             map_px;
   logic [9:0]              map_mask;
   logic [9:0]              ux, uy;
   logic                    clip;
   logic [13:0]             row_offset;
   logic [STORE_ADDR_W-1:0] map_addr;
   logic [STORE_ADDR_W-1:0] pattern_addr;

   // products of screen position and the four steps
   always_comb begin
      prod_xa_in = $signed({1'b0, pixel_x}) * cfg.step_x_per_col;
      prod_xb_in = $signed({1'b0, pixel_y}) * cfg.step_x_per_row;
      prod_yc_in = $signed({1'b0, pixel_x}) * cfg.step_y_per_col;
      prod_yd_in = $signed({1'b0, pixel_y}) * cfg.step_y_per_row;
   end

   // signed q21.8 sum, floor by dropping the fraction (arithmetic)
   always_comb begin
      sum_x = SUM_W'(cfg.origin_x) + SUM_W'(prod_xb_ff) + SUM_W'(prod_xa_ff);
      sum_y = SUM_W'(cfg.origin_y) + SUM_W'(prod_yd_ff) + SUM_W'(prod_yc_ff);
      fx_in = sum_x[SUM_W-1:8];
      fy_in = sum_y[SUM_W-1:8];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         prod_xa_ff <= prod_xa_in;
         prod_xb_ff <= prod_xb_in;
         prod_yc_ff <= prod_yc_in;
         prod_yd_ff <= prod_yd_in;
      end
      if (ctrl.sum_en) begin
         fx_ff <= fx_in;
         fy_ff <= fy_in;
      end
   end

   // wrap or clip, then tilemap address
   always_comb begin
      map_size     = cfg.bg_control[15:14];
      wrap         = cfg.bg_control[13];
      map_base     = {cfg.bg_control[12:8], 11'd0};
      pattern_base = {cfg.bg_control[3:2], 14'd0};
      map_px       = 11'd128 << map_size;
      map_mask     = 10'(map_px - 11'd1);
      ux = wrap ? (fx_ff[9:0] & map_mask) : fx_ff[9:0];
      uy = wrap ? (fy_ff[9:0] & map_mask) : fy_ff[9:0];
      clip = !wrap && (fx_ff[TEXEL_W-1] || fy_ff[TEXEL_W-1]
                       || !(fx_ff < $signed({10'd0, map_px}))
                       || !(fy_ff < $signed({10'd0, map_px})));
      // map is (16 << size) tiles wide
      row_offset   = {7'd0, uy[9:3]} << (3'd4 + {1'b0, map_size});
      map_addr     = STORE_ADDR_W'(map_base) + STORE_ADDR_W'(row_offset)
                   + STORE_ADDR_W'(ux[9:3]);
      pattern_addr = STORE_ADDR_W'(pattern_base) + {3'd0, tile_entry, 6'd0}
                   + STORE_ADDR_W'({fy_ff[2:0], fx_ff[2:0]});
   end

   always_comb begin
      stat.map_addr     = map_addr;
      stat.map_miss     = clip || ({15'd0, map_addr} >= 32'(VIDEO_BYTES));
      stat.pattern_addr = pattern_addr;
      stat.tile_miss    = {15'd0, pattern_addr} >= 32'(VIDEO_BYTES);
   end

endmodule

`default_nettype wire

/* hdl/affine_background_pixel_fetch_top.sv */
// top level of the affine background pixel fetch: control sequencer, csrs, stores, result register
//
//  channel | ports   | direction | handshake      | payload
//  --------+---------+-----------+----------------+------------------------------------------
//  request | req_*   | in        | valid / ready  | command, pixel x/y, store address, value
//  result  | rsp_*   | out       | valid / ready  | drawn, out x/y, red, green, blue
//  csr     | csr_*   | in        | write enable   | register index, 28-bit write data
//
// a render request runs from acceptance to the next acceptance, when the result side is
// free, through products, sum, map read, tile read, palette read, colour, result load;
// the three dependent reads of the registered-read video and palette rams set this sequence
// clipped, off-screen, out-of-store and transparent pixels leave the sequence early
// write requests complete at acceptance and the next request is taken in the next cycle
// synchronous reset clears the sequencer, the result valid and all csrs; store contents
// are undefined until written
// a stalled result holds the sequencer in its last state; a new request is taken while
// an earlier result still waits
`default_nettype none

module affine_background_pixel_fetch_top import abpf_pkg::*; #(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
   parameter int VIDEO_BYTES   = VIDEO_BYTES_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request channel
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [1:0]              req_command,
   input  wire logic [PIXEL_W-1:0]      req_pixel_x,
   input  wire logic [PIXEL_W-1:0]      req_pixel_y,
   input  wire logic [STORE_ADDR_W-1:0] req_store_address,
   input  wire logic [VALUE_W-1:0]      req_write_value,
   // result channel
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         rsp_drawn,
   output logic      [PIXEL_W-1:0]      rsp_out_x,
   output logic      [PIXEL_W-1:0]      rsp_out_y,
   output logic      [7:0]              rsp_red,
   output logic      [7:0]              rsp_green,
   output logic      [7:0]              rsp_blue,
   // csr write port
   input  wire logic                    csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_write_data
);

   localparam int VA_W = $clog2(VIDEO_BYTES);

   // one-hot sequencer
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,  // take requests, perform store writes
      ST_SUM   = 7'b0000010,  // floored texel position
      ST_MAP   = 7'b0000100,  // wrap/clip, issue tilemap read
      ST_TILE  = 7'b0001000,  // tilemap byte back, issue tile read
      ST_INDEX = 7'b0010000,  // colour index back, issue palette read
      ST_COLOR = 7'b0100000,  // palette colour back
      ST_DONE  = 7'b1000000   // hand the pixel to the result register
   } state_type;

   state_type               state_ff, state_in;
   cfg_type                 cfg_ff, cfg_in;
   logic [PIXEL_W-1:0]      x_ff, x_in;
   logic [PIXEL_W-1:0]      y_ff, y_in;
   logic                    drawn_ff, drawn_in;
   logic [COLOUR_W-1:0]     colour_ff, colour_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_drawn_ff;
   logic [PIXEL_W-1:0]      rsp_x_ff, rsp_y_ff;
   logic [7:0]              rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic                    rsp_load;

   addr_ctrl_type           addr_ctrl;
   addr_stat_type           addr_stat;

   logic                    req_fire;
   logic                    off_screen;
   logic                    vram_we, vram_re;
   logic [STORE_ADDR_W-1:0] vram_ra;
   logic [7:0]              vram_rd_data;
   logic                    pal_we, pal_re;
   logic [COLOUR_W-1:0]     pal_rd_data;

   function automatic logic [7:0] expand5(input logic [4:0] v);
      expand5 = {v, v[4:2]};
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign off_screen = ({3'd0, req_pixel_x} >= 11'(SCREEN_WIDTH))
                    || ({3'd0, req_pixel_y} >= 11'(SCREEN_HEIGHT));

   // csr writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (reg_index_type'(csr_index))
            REG_BG_CONTROL:     cfg_in.bg_control     = csr_write_data[15:0];
            REG_STEP_X_PER_COL: cfg_in.step_x_per_col = csr_write_data[STEP_W-1:0];
            REG_STEP_X_PER_ROW: cfg_in.step_x_per_row = csr_write_data[STEP_W-1:0];
            REG_STEP_Y_PER_COL: cfg_in.step_y_per_col = csr_write_data[STEP_W-1:0];
            REG_STEP_Y_PER_ROW: cfg_in.step_y_per_row = csr_write_data[STEP_W-1:0];
            REG_ORIGIN_X:       cfg_in.origin_x       = csr_write_data[ORIGIN_W-1:0];
            REG_ORIGIN_Y:       cfg_in.origin_y       = csr_write_data[ORIGIN_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in         = state_ff;
      x_in             = x_ff;
      y_in             = y_ff;
      drawn_in         = drawn_ff;
      colour_in        = colour_ff;
      addr_ctrl.load   = 1'b0;
      addr_ctrl.sum_en = 1'b0;
      vram_we          = 1'b0;
      vram_re          = 1'b0;
      vram_ra          = addr_stat.map_addr;
      pal_we           = 1'b0;
      pal_re           = 1'b0;
      rsp_load         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (cmd_type'(req_command))
                  CMD_RENDER: begin
                     addr_ctrl.load = 1'b1;
                     x_in           = req_pixel_x;
                     y_in           = req_pixel_y;
                     drawn_in       = 1'b0;
                     state_in       = off_screen ? ST_DONE : ST_SUM;
                  end
                  CMD_VIDEO_WRITE: begin
                     vram_we = ({15'd0, req_store_address} < 32'(VIDEO_BYTES));
                  end
                  CMD_PALETTE_WRITE: begin
                     pal_we = (req_store_address[STORE_ADDR_W-1:PAL_ADDR_W] == '0);
                  end
                  default: begin
                     state_in = ST_IDLE;  // unused code, dropped
                  end
               endcase
            end
         end
         ST_SUM: begin
            addr_ctrl.sum_en = 1'b1;
            state_in         = ST_MAP;
         end
         ST_MAP: begin
            if (addr_stat.map_miss) begin
               state_in = ST_DONE;
            end else begin
               vram_re  = 1'b1;
               vram_ra  = addr_stat.map_addr;
               state_in = ST_TILE;
            end
         end
         ST_TILE: begin
            if (addr_stat.tile_miss) begin
               state_in = ST_DONE;
            end else begin
               vram_re  = 1'b1;
               vram_ra  = addr_stat.pattern_addr;
               state_in = ST_INDEX;
            end
         end
         ST_INDEX: begin
            // colour index zero is transparent
            if (vram_rd_data == 8'd0) begin
               state_in = ST_DONE;
            end else begin
               pal_re   = 1'b1;
               state_in = ST_COLOR;
            end
         end
         ST_COLOR: begin
            drawn_in  = 1'b1;
            colour_in = pal_rd_data;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register, freed by the consumer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      drawn_ff  <= drawn_in;
      colour_ff <= colour_in;
      if (rsp_load) begin
         rsp_drawn_ff <= drawn_ff;
         rsp_x_ff     <= x_ff;
         rsp_y_ff     <= y_ff;
         // bgr555: red in the low field
         rsp_red_ff   <= drawn_ff ? expand5(colour_ff[4:0])   : 8'd0;
         rsp_green_ff <= drawn_ff ? expand5(colour_ff[9:5])   : 8'd0;
         rsp_blue_ff  <= drawn_ff ? expand5(colour_ff[14:10]) : 8'd0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drawn = rsp_drawn_ff;
   assign rsp_out_x = rsp_x_ff;
   assign rsp_out_y = rsp_y_ff;
   assign rsp_red   = rsp_red_ff;
   assign rsp_green = rsp_green_ff;
   assign rsp_blue  = rsp_blue_ff;

   // coordinate and address datapath
   abpf_addr #(
      .VIDEO_BYTES (VIDEO_BYTES)
   ) u_addr (
      .clock      (clock),
      .cfg        (cfg_ff),
      .pixel_x    (req_pixel_x),
      .pixel_y    (req_pixel_y),
      .ctrl       (addr_ctrl),
      .tile_entry (vram_rd_data),
      .stat       (addr_stat)
   );

   // video byte store: tilemap and tile data
   abpf_ram #(
      .WIDTH (8),
      .DEPTH (VIDEO_BYTES)
   ) u_vram (
      .clock   (clock),
      .wr_en   (vram_we),
      .wr_addr (req_store_address[VA_W-1:0]),
      .wr_data (req_write_value[7:0]),
      .rd_en   (vram_re),
      .rd_addr (vram_ra[VA_W-1:0]),
      .rd_data (vram_rd_data)
   );

   // palette store
   abpf_ram #(
      .WIDTH (COLOUR_W),
      .DEPTH (PALETTE_ENTRIES)
   ) u_pal (
      .clock   (clock),
      .wr_en   (pal_we),
      .wr_addr (req_store_address[PAL_ADDR_W-1:0]),
      .wr_data (req_write_value),
      .rd_en   (pal_re),
      .rd_addr (vram_rd_data),
      .rd_data (pal_rd_data)
   );

   // the palette colour is only taken right after its read
   a_color_after_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COLOR |-> $past(state_ff == ST_INDEX))
      else $error("colour stage without palette read");

   // an accepted render always leaves idle
   a_render_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_command == CMD_RENDER) |=> state_ff != ST_IDLE)
      else $error("render request not started");

   // a pending pixel is kept while the result register is blocked
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_ready) |=> state_ff == ST_DONE)
      else $error("pixel dropped under result stall");

endmodule

`default_nettype wire

/* test/tb_affine_background_pixel_fetch_top.sv */
// testbench for the affine background pixel fetch: store fills, renders across csr settings
`timescale 1ns / 1ps

module tb_affine_background_pixel_fetch_top import abpf_pkg::*; ();

   // block geometry as built with its default parameters
   localparam int SCREEN_WIDTH  = SCREEN_WIDTH_DEF;
   localparam int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF;
   localparam int VIDEO_BYTES   = VIDEO_BYTES_DEF;

   // bg_control field scaling
   localparam int CHAR_BLOCK = 16384;  // char base unit in bytes
   localparam int MAP_BLOCK  = 2048;   // map base unit in bytes
   localparam int TILE_BYTES = 64;     // one 8x8 tile at 8 bits per pixel

   // codes the package leaves unnamed
   localparam logic [1:0]             CMD_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;

   // run shape: requests per phase, store fills included
   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 62;
   localparam int SETTLE_CYCLES   = 16;      // covers a full render sequence and then some
   localparam int CYCLE_LIMIT     = 600000;  // far beyond the slowest correct run

   // what one result should carry
   typedef struct packed {
      logic       drawn;
      logic [7:0] out_x;
      logic [7:0] out_y;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_result_type;

   // path of one render through the stores
   typedef struct packed {
      logic                    map_read;
      logic [STORE_ADDR_W-1:0] map_addr;
      logic                    tile_read;
      logic [STORE_ADDR_W-1:0] pattern_addr;
      logic [7:0]              colour_index;
   } fetch_trace_type;

   // shadow of the block: csrs, both stores, and the pixels still owed
   class pixel_scoreboard_type;
      cfg_type          settings;
      bit [7:0]         video_mem [VIDEO_BYTES];
      bit               video_set [VIDEO_BYTES];
      bit [14:0]        palette_mem [PALETTE_ENTRIES];
      bit               palette_set [PALETTE_ENTRIES];
      pixel_result_type pending_pixels [$];
      int unsigned      failures;

      function new();
         settings = '0;
         failures = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_BG_CONTROL:     settings.bg_control     = data[15:0];
            REG_STEP_X_PER_COL: settings.step_x_per_col = data[15:0];
            REG_STEP_X_PER_ROW: settings.step_x_per_row = data[15:0];
            REG_STEP_Y_PER_COL: settings.step_y_per_col = data[15:0];
            REG_STEP_Y_PER_ROW: settings.step_y_per_row = data[15:0];
            REG_ORIGIN_X:       settings.origin_x       = data[27:0];
            REG_ORIGIN_Y:       settings.origin_y       = data[27:0];
            default: ;
         endcase
      endfunction

      // texel position, wrap or clip, then map byte and tile byte
      function fetch_trace_type trace_fetch(logic [7:0] px, logic [7:0] py);
         fetch_trace_type t;
         int tx, ty, fx, fy, map_px, ux, uy, map_addr, pattern_addr;
         t = '0;
         if (px >= SCREEN_WIDTH || py >= SCREEN_HEIGHT)
            return t;
         tx = $signed(settings.origin_x) + int'(py) * $signed(settings.step_x_per_row)
              + int'(px) * $signed(settings.step_x_per_col);
         ty = $signed(settings.origin_y) + int'(py) * $signed(settings.step_y_per_row)
              + int'(px) * $signed(settings.step_y_per_col);
         fx = tx >>> 8;
         fy = ty >>> 8;
         map_px = 128 << settings.bg_control[15:14];
         if (settings.bg_control[13]) begin
            ux = fx & (map_px - 1);
            uy = fy & (map_px - 1);
         end else begin
            if (fx < 0 || fy < 0 || fx >= map_px || fy >= map_px)
               return t;
            ux = fx;
            uy = fy;
         end
         map_addr = int'(settings.bg_control[12:8]) * MAP_BLOCK
                    + (uy >> 3) * (map_px >> 3) + (ux >> 3);
         if (map_addr >= VIDEO_BYTES)
            return t;
         t.map_read = 1'b1;
         t.map_addr = STORE_ADDR_W'(map_addr);
         pattern_addr = int'(settings.bg_control[3:2]) * CHAR_BLOCK
                        + int'(video_mem[map_addr]) * TILE_BYTES + (uy & 7) * 8 + (ux & 7);
         if (pattern_addr >= VIDEO_BYTES)
            return t;
         t.tile_read    = 1'b1;
         t.pattern_addr = STORE_ADDR_W'(pattern_addr);
         t.colour_index = video_mem[pattern_addr];
         return t;
      endfunction

      // next store entry that a render of (px, py) would read before it is written
      function bit first_unwritten(logic [7:0] px, logic [7:0] py,
                                   output logic [1:0] cmd, output logic [STORE_ADDR_W-1:0] addr);
         fetch_trace_type t;
         t = trace_fetch(px, py);
         cmd  = CMD_VIDEO_WRITE;
         addr = '0;
         if (t.map_read && !video_set[t.map_addr]) begin
            addr = t.map_addr;
            return 1'b1;
         end
         if (t.tile_read && !video_set[t.pattern_addr]) begin
            addr = t.pattern_addr;
            return 1'b1;
         end
         if (t.tile_read && t.colour_index != 8'd0 && !palette_set[t.colour_index]) begin
            cmd  = CMD_PALETTE_WRITE;
            addr = STORE_ADDR_W'(t.colour_index);
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function logic [7:0] widen5(logic [4:0] v);
         return {v, v[4:2]};
      endfunction

      function void absorb_request(logic [1:0] cmd, logic [7:0] px, logic [7:0] py,
                                   logic [STORE_ADDR_W-1:0] addr, logic [VALUE_W-1:0] value);
         fetch_trace_type  t;
         pixel_result_type want;
         logic [14:0]      colour;
         case (cmd)
            CMD_VIDEO_WRITE:
               if (addr < VIDEO_BYTES) begin
                  video_mem[addr] = value[7:0];
                  video_set[addr] = 1'b1;
               end
            CMD_PALETTE_WRITE:
               if (addr < PALETTE_ENTRIES) begin
                  palette_mem[addr[7:0]] = value;
                  palette_set[addr[7:0]] = 1'b1;
               end
            CMD_RENDER: begin
               want = '0;
               want.out_x = px;
               want.out_y = py;
               t = trace_fetch(px, py);
               // index 0 is transparent
               if (t.tile_read && t.colour_index != 8'd0) begin
                  colour     = palette_mem[t.colour_index];
                  want.drawn = 1'b1;
                  want.red   = widen5(colour[4:0]);
                  want.green = widen5(colour[9:5]);
                  want.blue  = widen5(colour[14:10]);
               end
               pending_pixels.push_back(want);
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void match_pixel(logic drawn, logic [7:0] x, logic [7:0] y,
                                logic [7:0] r, logic [7:0] g, logic [7:0] b);
         pixel_result_type want;
         if (pending_pixels.size() == 0) begin
            $error("pixel x %0d y %0d arrived with no render outstanding", x, y);
            failures++;
            return;
         end
         want = pending_pixels.pop_front();
         compare_field("drawn", 8'(want.drawn), 8'(drawn));
         compare_field("out_x", want.out_x, x);
         compare_field("out_y", want.out_y, y);
         compare_field("red", want.red, r);
         compare_field("green", want.green, g);
         compare_field("blue", want.blue, b);
      endfunction

      function int waiting();
         return pending_pixels.size();
      endfunction
   endclass

   // block ports
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [1:0]              req_command = CMD_RENDER;
   logic [PIXEL_W-1:0]      req_pixel_x = '0;
   logic [PIXEL_W-1:0]      req_pixel_y = '0;
   logic [STORE_ADDR_W-1:0] req_store_address = '0;
   logic [VALUE_W-1:0]      req_write_value = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_drawn;
   logic [PIXEL_W-1:0]      rsp_out_x;
   logic [PIXEL_W-1:0]      rsp_out_y;
   logic [7:0]              rsp_red;
   logic [7:0]              rsp_green;
   logic [7:0]              rsp_blue;
   logic                    csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_write_data = '0;

   pixel_scoreboard_type pixels;
   int unsigned          requests_taken = 0;
   // idle odds in percent for each side of the block
   int unsigned          send_idle_pct = 28;
   int unsigned          recv_idle_pct = 85;

   affine_background_pixel_fetch_top dut (.*);

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // both handshakes are sampled here, the result before the request so that a
   // pixel can never be matched against the render taken at the same edge
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            pixels.match_pixel(rsp_drawn, rsp_out_x, rsp_out_y, rsp_red, rsp_green, rsp_blue);
         if (req_valid && req_ready) begin
            pixels.absorb_request(req_command, req_pixel_x, req_pixel_y,
                                  req_store_address, req_write_value);
            requests_taken++;
         end
         // result side stalls at random
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // hang guard
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("** affine_background_pixel_fetch_top: FAILED **");
      $finish;
   end

   // one request; returns at the edge that accepts it, after the scoreboard saw it
   task automatic send_request(input logic [1:0] cmd, input logic [7:0] px, input logic [7:0] py,
                               input logic [STORE_ADDR_W-1:0] addr,
                               input logic [VALUE_W-1:0] value);
      int unsigned ticket;
      // sender gap, valid dropped only between requests
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_pixel_x       <= px;
      req_pixel_y       <= py;
      req_store_address <= addr;
      req_write_value   <= value;
      ticket = requests_taken + 1;
      wait (requests_taken == ticket);
   endtask

   // fill whatever the render would read that is still unwritten, then render
   task automatic render_pixel(input logic [7:0] px, input logic [7:0] py);
      logic [1:0]              cmd;
      logic [STORE_ADDR_W-1:0] addr;
      logic [VALUE_W-1:0]      value;
      while (pixels.first_unwritten(px, py, cmd, addr)) begin
         value = VALUE_W'($urandom);
         // some tile bytes come out transparent
         if (cmd == CMD_VIDEO_WRITE && $urandom_range(7) == 0)
            value[7:0] = 8'h00;
         send_request(cmd, 8'($urandom), 8'($urandom), addr, value);
      end
      send_request(CMD_RENDER, px, py, STORE_ADDR_W'($urandom), VALUE_W'($urandom));
   endtask

   // hold requests until every owed pixel is back and the sequencer has drained
   task automatic drain();
      req_valid <= 1'b0;
      while (pixels.waiting() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      pixels.set_register(idx, data);
   endtask

   // csrs change only with the block idle; upper bits of 16-bit registers carry junk
   task automatic load_settings(input cfg_type c);
      drain();
      write_register(REG_BG_CONTROL, {12'($urandom), c.bg_control});
      write_register(REG_STEP_X_PER_COL, {12'($urandom), c.step_x_per_col});
      write_register(REG_STEP_X_PER_ROW, {12'($urandom), c.step_x_per_row});
      write_register(REG_STEP_Y_PER_COL, {12'($urandom), c.step_y_per_col});
      write_register(REG_STEP_Y_PER_ROW, {12'($urandom), c.step_y_per_row});
      write_register(REG_ORIGIN_X, c.origin_x);
      write_register(REG_ORIGIN_Y, c.origin_y);
      write_register(REG_UNUSED, CSR_DATA_W'($urandom));
      csr_write_enable <= 1'b0;
   endtask

   // every step and origin at its top or bottom end; bg_control all ones or wrap bit only
   function automatic cfg_type extreme_settings(bit top);
      cfg_type c;
      c.bg_control     = top ? 16'hFFFF : 16'h2000;
      c.step_x_per_col = top ? 16'h7FFF : 16'h8000;
      c.step_x_per_row = top ? 16'h7FFF : 16'h8000;
      c.step_y_per_col = top ? 16'h7FFF : 16'h8000;
      c.step_y_per_row = top ? 16'h7FFF : 16'h8000;
      c.origin_x       = top ? 28'h7FFFFFF : 28'h8000000;
      c.origin_y       = top ? 28'h7FFFFFF : 28'h8000000;
      return c;
   endfunction

   // steps near unit scale and origins near the map keep most pixels on it;
   // wild settings take any bit pattern
   function automatic cfg_type random_settings(bit wild);
      cfg_type c;
      c.bg_control = 16'($urandom);
      if (wild) begin
         c.step_x_per_col = 16'($urandom);
         c.step_x_per_row = 16'($urandom);
         c.step_y_per_col = 16'($urandom);
         c.step_y_per_row = 16'($urandom);
         c.origin_x       = 28'($urandom);
         c.origin_y       = 28'($urandom);
      end else begin
         c.step_x_per_col = 16'($urandom_range(0, 1024) - 512);
         c.step_x_per_row = 16'($urandom_range(0, 1024) - 512);
         c.step_y_per_col = 16'($urandom_range(0, 1024) - 512);
         c.step_y_per_row = 16'($urandom_range(0, 1024) - 512);
         c.origin_x       = 28'($urandom_range(0, 262144) - 131072);
         c.origin_y       = 28'($urandom_range(0, 262144) - 131072);
      end
      return c;
   endfunction

   // mostly renders on screen, plus stray writes, ignored codes and off-screen pixels
   task automatic random_item();
      int unsigned pick;
      logic [7:0]  px, py;
      pick = $urandom_range(99);
      px = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, SCREEN_WIDTH - 1));
      py = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, SCREEN_HEIGHT - 1));
      if (pick < 72)
         render_pixel(px, py);
      else if (pick < 84)
         send_request(CMD_VIDEO_WRITE, px, py, STORE_ADDR_W'($urandom), VALUE_W'($urandom));
      else if (pick < 94)
         send_request(CMD_PALETTE_WRITE, px, py,
                      ($urandom_range(3) == 0) ? STORE_ADDR_W'($urandom)
                                               : STORE_ADDR_W'($urandom_range(0, 255)),
                      VALUE_W'($urandom));
      else
         send_request(CMD_UNUSED, px, py, STORE_ADDR_W'($urandom), VALUE_W'($urandom));
   endtask

   initial begin
      cfg_type     c;
      int unsigned target;
      pixels = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // identity mapping, 128-texel map, clipping, both bases at zero
      c = '0;
      c.step_x_per_col = 16'sh0100;
      c.step_y_per_row = 16'sh0100;
      load_settings(c);

      // palette ends, and writes that must be dropped
      send_request(CMD_PALETTE_WRITE, 8'd0, 8'd0, 17'd255, 15'h7FFF);
      send_request(CMD_PALETTE_WRITE, 8'd0, 8'd0, 17'd0, 15'h7FFF);
      send_request(CMD_PALETTE_WRITE, 8'd0, 8'd0, 17'd256, 15'h1234);
      send_request(CMD_PALETTE_WRITE, 8'd0, 8'd0, 17'h1FFFF, 15'h0000);
      // video store ends, beyond-store writes dropped
      send_request(CMD_VIDEO_WRITE, 8'd0, 8'd0, 17'h1FFFF, 15'h7FFF);
      send_request(CMD_VIDEO_WRITE, 8'd0, 8'd0, VIDEO_BYTES, 15'h7FFF);
      send_request(CMD_VIDEO_WRITE, 8'd0, 8'd0, VIDEO_BYTES - 1, 15'h7FFF);
      // map byte 0 at address 0 points at tile 0, whose first pixel is that same zero
      send_request(CMD_VIDEO_WRITE, 8'd0, 8'd0, 17'd0, 15'h0000);
      send_request(CMD_VIDEO_WRITE, 8'd0, 8'd0, 17'd1, 15'h00FF);
      send_request(CMD_UNUSED, 8'hFF, 8'hFF, 17'h1FFFF, 15'h7FFF);
      render_pixel(8'd0, 8'd0);      // transparent
      render_pixel(8'd1, 8'd0);      // palette top entry, full white
      render_pixel(8'd127, 8'd127);  // last texel of the map
      render_pixel(8'd128, 8'd5);    // clipped right
      render_pixel(8'd5, 8'd128);    // clipped below
      render_pixel(8'd239, 8'd159);  // last screen pixel, clipped
      render_pixel(8'd240, 8'd0);    // off-screen right
      render_pixel(8'd0, 8'd160);    // off-screen below
      render_pixel(8'd255, 8'd255);

      // wrapping with origin x just below zero and origin y one texel negative, 256-texel map
      c.bg_control = 16'h6000;
      c.origin_x   = 28'hFFFFFFF;
      c.origin_y   = 28'hFFFFF00;
      load_settings(c);
      render_pixel(8'd0, 8'd0);
      render_pixel(8'd100, 8'd50);
      render_pixel(8'd239, 8'd159);

      for (int phase = 0; phase < PHASES; phase++) begin
         // idle pattern: sender light and receiver heavy, then swapped, then none
         if (phase == 4) begin
            send_idle_pct = 85;
            recv_idle_pct = 28;
         end
         if (phase == 7) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (phase)
            0:       c = extreme_settings(1'b1);
            2:       c = extreme_settings(1'b0);
            4, 8:    c = random_settings(1'b1);
            default: c = random_settings(1'b0);
         endcase
         load_settings(c);
         target = requests_taken + ITEMS_PER_PHASE;
         while (requests_taken < target)
            random_item();
      end

      drain();
      if (pixels.failures == 0 && pixels.waiting() == 0)
         $display("** affine_background_pixel_fetch_top: PASSED **");
      else
         $display("** affine_background_pixel_fetch_top: FAILED **");
      $finish;
   end

endmodule
